### hdl/icp_pkg.sv
// Shared constants, codes and controller/datapath handshake types for the Intcode processor.
package icp_pkg;

  localparam int MEM_WORDS_DEF = 4096;

  localparam int S_DATA_W = 144;
  localparam int M_DATA_W = 72;

  localparam logic [6:0] OP_ADD  = 7'd1;
  localparam logic [6:0] OP_MUL  = 7'd2;
  localparam logic [6:0] OP_IN   = 7'd3;
  localparam logic [6:0] OP_OUT  = 7'd4;
  localparam logic [6:0] OP_JT   = 7'd5;
  localparam logic [6:0] OP_JF   = 7'd6;
  localparam logic [6:0] OP_LT   = 7'd7;
  localparam logic [6:0] OP_EQ   = 7'd8;
  localparam logic [6:0] OP_ARB  = 7'd9;
  localparam logic [6:0] OP_HALT = 7'd99;

  localparam logic [3:0] DIGIT_RADIX = 4'd10;
  localparam int         NUM_DIGITS  = 5;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_HALT  = 2'd2;
  localparam logic [1:0] ST_FAULT = 2'd3;

  localparam logic [2:0] A_CLR  = 3'd0;
  localparam logic [2:0] A_LOAD = 3'd1;
  localparam logic [2:0] A_PC   = 3'd2;
  localparam logic [2:0] A_SLOT = 3'd3;
  localparam logic [2:0] A_EFF  = 3'd4;
  localparam logic [2:0] A_C    = 3'd5;

  localparam logic [1:0] D_ZERO = 2'd0;
  localparam logic [1:0] D_LOAD = 2'd1;
  localparam logic [1:0] D_IN   = 2'd2;
  localparam logic [1:0] D_RES  = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       clr_inc;
    logic       mem_we;
    logic [2:0] asel;
    logic [1:0] dsel;
    logic       op_ld;
    logic       div_step;
    logic [1:0] opnd;
    logic       eff_slot;
    logic       eff_word;
    logic       c_ld;
    logic       a_ld;
    logic       b_ld;
    logic       alu_ld;
    logic       mul_step;
    logic [1:0] mul_sel;
    logic       base_add;
    logic       out_set;
    logic       take_set;
    logic       npc_ld;
    logic       pc_upd;
    logic       stop_we;
    logic [1:0] stop_val;
    logic       res_ld;
  } cmd_t;

  typedef struct packed {
    logic       mode;
    logic       in_valid;
    logic [1:0] stopped;
    logic       op_neg;
    logic       div_done;
    logic [6:0] instr;
    logic       slot_ok;
    logic       imm;
    logic       eff_ok;
    logic       npc_ok;
    logic       ld_ok;
    logic       out_free;
    logic       clr_last;
  } sts_t;

endpackage

### hdl/icp_ram.sv
// Generic single-port RAM with registered read data.
module icp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hdl/icp_dp.sv
// Datapath: machine registers, decimal digit unit, operand addressing, ALU and program memory.
module icp_dp #(
  parameter int MEM_WORDS = icp_pkg::MEM_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  icp_pkg::cmd_t                 cmd,
  output icp_pkg::sts_t                 sts,
  input  logic [icp_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [icp_pkg::M_DATA_W-1:0]  m_tdata
);

  localparam int          AW   = $clog2(MEM_WORDS);
  localparam logic [63:0] MW64 = 64'(MEM_WORDS);
  localparam logic [AW:0] MWS  = (AW+1)'(MEM_WORDS);
  localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);

  // Latched item fields.
  logic        it_mode;
  logic [11:0] it_ldaddr;
  logic [63:0] it_ldval;
  logic        it_inv;
  logic [63:0] it_inval;

  logic [AW-1:0] clr;
  logic [AW-1:0] pc;
  logic [63:0]   base;
  logic [1:0]    stopped;
  logic [63:0]   op;
  logic [63:0]   qw;
  logic [3:0]    rem;
  logic [2:0]    bytecnt;
  logic [2:0]    didx;
  logic [3:0]    dig [icp_pkg::NUM_DIGITS];
  logic [63:0]   eff;
  logic [AW-1:0] c;
  logic [63:0]   a;
  logic [63:0]   b;
  logic [63:0]   r;
  logic [63:0]   prod;
  logic [63:0]   npc;
  logic          ov;
  logic [63:0]   oval;
  logic          taken;

  logic [63:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [63:0]   mem_wdata;

  logic [6:0]    instr;
  logic [3:0]    mdig;
  logic [AW:0]   slot;
  logic [63:0]   ld64;
  logic [7:0]    qbyte;
  logic [3:0]    rem_next;
  logic [31:0]   mx;
  logic [31:0]   my;

  icp_ram #(.WIDTH(64), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  assign instr = 7'(dig[1]) * 7'(icp_pkg::DIGIT_RADIX) + 7'(dig[0]);
  assign slot  = {1'b0, pc} + (AW+1)'(cmd.opnd);
  assign ld64  = 64'(it_ldaddr);

  always_comb begin
    case (cmd.opnd)
      2'd1:    mdig = dig[2];
      2'd2:    mdig = dig[3];
      default: mdig = dig[4];
    endcase
  end

  // Eight steps of long division by ten over the top byte of the shift register.
  always_comb begin
    logic [4:0] t;
    logic [3:0] rr;
    rr = rem;
    qbyte = '0;
    for (int i = 0; i < 8; i++) begin
      t = {rr, qw[63-i]};
      if (t >= 5'(icp_pkg::DIGIT_RADIX)) begin
        qbyte[7-i] = 1'b1;
        rr = 4'(t - 5'(icp_pkg::DIGIT_RADIX));
      end else begin
        rr = t[3:0];
      end
    end
    rem_next = rr;
  end

  always_comb begin
    case (cmd.mul_sel)
      2'd0: begin
        mx = a[31:0];
        my = b[31:0];
      end
      2'd1: begin
        mx = a[31:0];
        my = b[63:32];
      end
      default: begin
        mx = a[63:32];
        my = b[31:0];
      end
    endcase
  end

  always_comb begin
    mem_we = cmd.mem_we;
    case (cmd.asel)
      icp_pkg::A_CLR:  mem_addr = clr;
      icp_pkg::A_LOAD: mem_addr = ld64[AW-1:0];
      icp_pkg::A_PC:   mem_addr = pc;
      icp_pkg::A_SLOT: mem_addr = slot[AW-1:0];
      icp_pkg::A_EFF:  mem_addr = eff[AW-1:0];
      icp_pkg::A_C:    mem_addr = c;
      default:         mem_addr = pc;
    endcase
    case (cmd.dsel)
      icp_pkg::D_ZERO: mem_wdata = '0;
      icp_pkg::D_LOAD: mem_wdata = it_ldval;
      icp_pkg::D_IN:   mem_wdata = it_inval;
      default:         mem_wdata = r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr      <= '0;
      pc       <= '0;
      base     <= '0;
      stopped  <= icp_pkg::ST_RUN;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr_inc) begin
        clr <= clr + AW'(1);
      end
      if (cmd.base_add) begin
        base <= base + a;
      end
      if (cmd.pc_upd) begin
        pc <= npc[AW-1:0];
      end
      if (cmd.stop_we) begin
        stopped <= cmd.stop_val;
      end
      if (cmd.res_ld) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_mode   <= s_tuser[0];
      it_ldaddr <= s_tdata[11:0];
      it_ldval  <= s_tdata[75:12];
      it_inv    <= s_tdata[76];
      it_inval  <= s_tdata[140:77];
      ov        <= 1'b0;
      oval      <= '0;
      taken     <= 1'b0;
    end
    if (cmd.op_ld) begin
      op      <= rdata;
      qw      <= rdata;
      rem     <= '0;
      bytecnt <= '0;
      didx    <= '0;
    end
    if (cmd.div_step) begin
      qw      <= {qw[55:0], qbyte};
      bytecnt <= bytecnt + 3'd1;
      if (bytecnt == 3'd7) begin
        dig[didx] <= rem_next;
        rem       <= '0;
        didx      <= didx + 3'd1;
      end else begin
        rem <= rem_next;
      end
    end
    if (cmd.eff_slot) begin
      eff <= 64'(slot);
    end
    if (cmd.eff_word) begin
      eff <= (mdig == 4'd0) ? rdata : rdata + base;
    end
    if (cmd.c_ld) begin
      c <= eff[AW-1:0];
    end
    if (cmd.a_ld) begin
      a <= rdata;
    end
    if (cmd.b_ld) begin
      b <= rdata;
    end
    if (cmd.alu_ld) begin
      case (instr)
        icp_pkg::OP_ADD: r <= a + b;
        icp_pkg::OP_LT:  r <= 64'($signed(a) < $signed(b));
        default:         r <= 64'(a == b);
      endcase
    end
    if (cmd.mul_step) begin
      prod <= mx * my;
      case (cmd.mul_sel)
        2'd0:    r <= r;
        2'd1:    r <= prod;
        default: r <= r + {prod[31:0], 32'd0};
      endcase
    end
    if (cmd.out_set) begin
      ov   <= 1'b1;
      oval <= a;
    end
    if (cmd.take_set) begin
      taken <= 1'b1;
    end
    if (cmd.npc_ld) begin
      case (instr)
        icp_pkg::OP_JT: npc <= (a != 64'd0) ? b : 64'(pc) + 64'd3;
        icp_pkg::OP_JF: npc <= (a == 64'd0) ? b : 64'(pc) + 64'd3;
        icp_pkg::OP_ADD, icp_pkg::OP_MUL, icp_pkg::OP_LT, icp_pkg::OP_EQ:
          npc <= 64'(pc) + 64'd4;
        default: npc <= 64'(pc) + 64'd2;
      endcase
    end
    if (cmd.res_ld) begin
      m_tdata <= {4'd0, stopped, taken, oval, ov};
    end
  end

  always_comb begin
    sts.mode     = it_mode;
    sts.in_valid = it_inv;
    sts.stopped  = stopped;
    sts.op_neg   = op[63];
    sts.div_done = (didx == 3'(icp_pkg::NUM_DIGITS));
    sts.instr    = instr;
    sts.slot_ok  = (slot < MWS);
    sts.imm      = (mdig == 4'd1);
    sts.eff_ok   = (eff < MW64);
    sts.npc_ok   = (npc < MW64);
    sts.ld_ok    = (ld64 < MW64);
    sts.out_free = !m_tvalid || m_tready;
    sts.clr_last = (clr == LAST);
  end

endmodule

### hdl/icp_ctrl.sv
// Controller state machine that sequences fetch, decode, operand access and execution.
module icp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  icp_pkg::sts_t sts,
  output icp_pkg::cmd_t cmd
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_LOAD  = 5'd3;
  localparam logic [4:0] S_FETCH = 5'd4;
  localparam logic [4:0] S_OPLD  = 5'd5;
  localparam logic [4:0] S_DIV   = 5'd6;
  localparam logic [4:0] S_DEC   = 5'd7;
  localparam logic [4:0] S_SLOT  = 5'd8;
  localparam logic [4:0] S_SLOTW = 5'd9;
  localparam logic [4:0] S_CHK   = 5'd10;
  localparam logic [4:0] S_VALW  = 5'd11;
  localparam logic [4:0] S_EXEC  = 5'd12;
  localparam logic [4:0] S_MUL   = 5'd13;
  localparam logic [4:0] S_WR    = 5'd14;
  localparam logic [4:0] S_NPC   = 5'd15;
  localparam logic [4:0] S_FIN   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state, state_next;
  logic [1:0] k, k_next;
  logic [1:0] mulcnt, mulcnt_next;

  logic is_arith, is_jump, is_one, wr_opnd, last_read;

  always_comb begin
    is_arith = (sts.instr == icp_pkg::OP_ADD) || (sts.instr == icp_pkg::OP_MUL) ||
               (sts.instr == icp_pkg::OP_LT) || (sts.instr == icp_pkg::OP_EQ);
    is_jump  = (sts.instr == icp_pkg::OP_JT) || (sts.instr == icp_pkg::OP_JF);
    is_one   = (sts.instr == icp_pkg::OP_OUT) || (sts.instr == icp_pkg::OP_ARB);
    wr_opnd  = (is_arith && k == 2'd3) || (sts.instr == icp_pkg::OP_IN && k == 2'd1);
    last_read = (is_jump && k == 2'd2) || (is_one && k == 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLR;
      k      <= 2'd1;
      mulcnt <= 2'd0;
    end else begin
      state  <= state_next;
      k      <= k_next;
      mulcnt <= mulcnt_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    k_next      = k;
    mulcnt_next = mulcnt;
    cmd         = '0;
    cmd.opnd    = k;
    cmd.mul_sel = mulcnt;
    cmd.asel    = icp_pkg::A_PC;
    cmd.dsel    = icp_pkg::D_RES;
    case (state)
      S_CLR: begin
        cmd.mem_we  = 1'b1;
        cmd.asel    = icp_pkg::A_CLR;
        cmd.dsel    = icp_pkg::D_ZERO;
        cmd.clr_inc = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts.mode) begin
          state_next = S_LOAD;
        end else if (sts.stopped == icp_pkg::ST_HALT || sts.stopped == icp_pkg::ST_FAULT) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_LOAD: begin
        cmd.asel   = icp_pkg::A_LOAD;
        cmd.dsel   = icp_pkg::D_LOAD;
        cmd.mem_we = sts.ld_ok;
        state_next = S_DONE;
      end
      S_FETCH: begin
        state_next = S_OPLD;
      end
      S_OPLD: begin
        cmd.op_ld  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.op_neg) begin
          cmd.stop_we  = 1'b1;
          cmd.stop_val = icp_pkg::ST_FAULT;
          state_next   = S_DONE;
        end else if (sts.div_done) begin
          state_next = S_DEC;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DEC: begin
        k_next = 2'd1;
        if (sts.instr == icp_pkg::OP_HALT) begin
          cmd.stop_we  = 1'b1;
          cmd.stop_val = icp_pkg::ST_HALT;
          state_next   = S_DONE;
        end else if (sts.instr == icp_pkg::OP_IN && !sts.in_valid) begin
          cmd.stop_we  = 1'b1;
          cmd.stop_val = icp_pkg::ST_WAIT;
          state_next   = S_DONE;
        end else if (is_arith || is_jump || is_one || sts.instr == icp_pkg::OP_IN) begin
          state_next = S_SLOT;
        end else begin
          cmd.stop_we  = 1'b1;
          cmd.stop_val = icp_pkg::ST_FAULT;
          state_next   = S_DONE;
        end
      end
      S_SLOT: begin
        cmd.asel = icp_pkg::A_SLOT;
        if (!sts.slot_ok) begin
          cmd.stop_we  = 1'b1;
          cmd.stop_val = icp_pkg::ST_FAULT;
          state_next   = S_DONE;
        end else if (sts.imm) begin
          cmd.eff_slot = 1'b1;
          state_next   = S_CHK;
        end else begin
          state_next = S_SLOTW;
        end
      end
      S_SLOTW: begin
        cmd.eff_word = 1'b1;
        state_next   = S_CHK;
      end
      S_CHK: begin
        cmd.asel = icp_pkg::A_EFF;
        if (!sts.eff_ok) begin
          cmd.stop_we  = 1'b1;
          cmd.stop_val = icp_pkg::ST_FAULT;
          state_next   = S_DONE;
        end else if (wr_opnd) begin
          cmd.c_ld   = 1'b1;
          state_next = S_EXEC;
        end else begin
          state_next = S_VALW;
        end
      end
      S_VALW: begin
        cmd.a_ld = (k == 2'd1);
        cmd.b_ld = (k != 2'd1);
        if (last_read) begin
          state_next = S_EXEC;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_SLOT;
        end
      end
      S_EXEC: begin
        mulcnt_next = 2'd0;
        if (sts.instr == icp_pkg::OP_MUL) begin
          state_next = S_MUL;
        end else if (is_arith || sts.instr == icp_pkg::OP_IN) begin
          cmd.alu_ld = is_arith;
          state_next = S_WR;
        end else begin
          cmd.out_set  = (sts.instr == icp_pkg::OP_OUT);
          cmd.base_add = (sts.instr == icp_pkg::OP_ARB);
          state_next   = S_NPC;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        mulcnt_next  = mulcnt + 2'd1;
        if (mulcnt == 2'd3) begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.mem_we = 1'b1;
        cmd.asel   = icp_pkg::A_C;
        if (sts.instr == icp_pkg::OP_IN) begin
          cmd.dsel     = icp_pkg::D_IN;
          cmd.take_set = 1'b1;
        end
        state_next = S_NPC;
      end
      S_NPC: begin
        cmd.npc_ld = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.stop_we = 1'b1;
        if (sts.npc_ok) begin
          cmd.pc_upd   = 1'b1;
          cmd.stop_val = icp_pkg::ST_RUN;
        end else begin
          cmd.stop_val = icp_pkg::ST_FAULT;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/intcode_processor.sv
// Top level of the Intcode processor: stream ports, controller and datapath.
//
// The block is a small stored-program machine with a 64-bit word memory of
// MEM_WORDS entries and one memory port. A load item writes one word if its
// address lies below MEM_WORDS, and an execute item runs at most one
// instruction; either way exactly one result item comes back with the output
// value, the input-consumed flag and the machine status. After reset the block
// first sweeps the memory to zero, one word per cycle, and accepts no item
// until the sweep ends. Items are then handled one at a time. For an execute
// item the opcode word is split into its five low decimal digits by a
// divide-by-ten unit that retires eight bits per cycle, each operand is then
// fetched over the single memory port, and a multiply builds its product from
// partial products on one shared 32 by 32 bit multiplier. A halt, an input with
// nothing offered or an unknown opcode ends the item right after decode. A
// halted or faulted machine answers an execute item without running it; only
// reset leaves those states. A finished result sits in the output register, so
// the next item can be taken while it waits.
module intcode_processor #(
  parameter int MEM_WORDS = icp_pkg::MEM_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // load_address[11:0], load_value[75:12], in_valid[76], in_value[140:77], zero pad
  input  logic [icp_pkg::S_DATA_W-1:0]  s_tdata,
  // mode[0]: 0 loads a program word, 1 executes an instruction
  input  logic [0:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out_valid[0], out_value[64:1], input_taken[65], status[67:66], zero pad
  output logic [icp_pkg::M_DATA_W-1:0]  m_tdata
);

  icp_pkg::cmd_t cmd;
  icp_pkg::sts_t sts;

  // The controller owns all sequencing; the datapath holds machine state.
  icp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  icp_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
